>>> rtl/core/gsbf_pkg.sv
// ----------------------------------------------------------------------------
// gsbf_pkg
// Shared types, constants and helper functions of the gzip stored-block framer.
// ----------------------------------------------------------------------------
package gsbf_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_FINISH = 2'd2
    } gsbf_mode_t;

    // Command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_DATA_HDR = 2'd1,
        CMD_DATA     = 2'd2,
        CMD_FINISH   = 2'd3
    } gsbf_cmd_kind_t;

    // One queued command: everything the back end needs to emit its bytes
    typedef struct packed {
        gsbf_cmd_kind_t kind;
        logic [7:0]     data_byte;
        logic [15:0]    blk_len;
        logic [31:0]    crc;
        logic [31:0]    total;
    } gsbf_cmd_t;

    // Queue status seen by front end and assertions
    typedef struct packed {
        logic full;
        logic empty;
    } gsbf_q_status_t;

    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam logic [15:0] MAX_STORED_LEN = 16'hffff;
    localparam logic [31:0] CRC_POLY       = 32'hedb88320;
    localparam int unsigned IDX_W          = 4;

    // Number of output bytes of each command kind
    function automatic logic [IDX_W-1:0] gsbf_cmd_bytes(input gsbf_cmd_kind_t kind);
        logic [IDX_W-1:0] n;
        case (kind)
            CMD_START:    n = 4'd10;
            CMD_DATA_HDR: n = 4'd6;
            CMD_DATA:     n = 4'd1;
            CMD_FINISH:   n = 4'd13;
            default:      n = 4'd1;
        endcase
        return n;
    endfunction

    // Fixed 10-byte gzip member header
    function automatic logic [7:0] gsbf_gz_hdr(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h1f;
            4'd1:    b = 8'h8b;
            4'd2:    b = 8'h08;
            4'd8:    b = 8'h02;
            4'd9:    b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Fold one byte into a finished (post-inverted) reflected CRC-32
    function automatic logic [31:0] gsbf_crc_byte(input logic [31:0] crc,
                                                  input logic [7:0]  b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

>>> rtl/core/gsbf_front.sv
// ----------------------------------------------------------------------------
// gsbf_front
// Accepts input transactions, keeps CRC, length and block state, and queues
// one command per start, data or finish transaction for the back end.
// ----------------------------------------------------------------------------
module gsbf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic [7:0]              s_data_byte,
    input  logic [31:0]             s_segment_remaining,
    input  gsbf_pkg::gsbf_q_status_t q_status,
    output logic                    push,
    output gsbf_pkg::gsbf_cmd_t     push_cmd
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] total_reg, total_next;
    logic [15:0] left_reg, left_next;
    logic        accept;
    logic [15:0] new_len;

    assign s_ready = ~q_status.full;
    assign accept  = s_valid & s_ready;

    // Stored block length: segment remainder clamped to 1..65535
    always_comb begin
        if (s_segment_remaining == 32'd0) begin
            new_len = 16'd1;
        end else if (s_segment_remaining > {16'd0, gsbf_pkg::MAX_STORED_LEN}) begin
            new_len = gsbf_pkg::MAX_STORED_LEN;
        end else begin
            new_len = s_segment_remaining[15:0];
        end
    end

    // Classify the transaction and work out the state update
    always_comb begin
        crc_next           = crc_reg;
        total_next         = total_reg;
        left_next          = left_reg;
        push               = 1'b0;
        push_cmd.kind      = gsbf_pkg::CMD_DATA;
        push_cmd.data_byte = s_data_byte;
        push_cmd.blk_len   = new_len;
        push_cmd.crc       = crc_reg;
        push_cmd.total     = total_reg;
        case (gsbf_pkg::gsbf_mode_t'(s_mode))
            gsbf_pkg::MODE_START: begin
                push          = accept;
                push_cmd.kind = gsbf_pkg::CMD_START;
                if (accept) begin
                    crc_next   = 32'd0;
                    total_next = 32'd0;
                    left_next  = 16'd0;
                end
            end
            gsbf_pkg::MODE_DATA: begin
                push          = accept;
                push_cmd.kind = (left_reg == 16'd0) ? gsbf_pkg::CMD_DATA_HDR
                                                    : gsbf_pkg::CMD_DATA;
                if (accept) begin
                    crc_next   = gsbf_pkg::gsbf_crc_byte(crc_reg, s_data_byte);
                    total_next = total_reg + 32'd1;
                    left_next  = ((left_reg == 16'd0) ? new_len : left_reg) - 16'd1;
                end
            end
            gsbf_pkg::MODE_FINISH: begin
                push          = accept;
                push_cmd.kind = gsbf_pkg::CMD_FINISH;
                if (accept) begin
                    left_next = 16'd0;
                end
            end
            default: begin
                // unused mode: taken and dropped
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= 32'd0;
            total_reg <= 32'd0;
            left_reg  <= 16'd0;
        end else begin
            crc_reg   <= crc_next;
            total_reg <= total_next;
            left_reg  <= left_next;
        end
    end

endmodule

>>> rtl/core/gsbf_queue.sv
// ----------------------------------------------------------------------------
// gsbf_queue
// Small register FIFO of commands between front and back end.
// ----------------------------------------------------------------------------
module gsbf_queue #(
    parameter int unsigned DEPTH = gsbf_pkg::QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  gsbf_pkg::gsbf_cmd_t      push_cmd,
    input  logic                     pop,
    output gsbf_pkg::gsbf_cmd_t      pop_cmd,
    output gsbf_pkg::gsbf_q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gsbf_pkg::gsbf_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/gsbf_back.sv
// ----------------------------------------------------------------------------
// gsbf_back
// Takes commands from the queue and emits their bytes one per cycle, while
// m_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module gsbf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  gsbf_pkg::gsbf_cmd_t q_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_last
);

    localparam int unsigned IDX_W = gsbf_pkg::IDX_W;

    gsbf_pkg::gsbf_cmd_t cmd_reg, cmd_next;
    logic                cmd_valid_reg, cmd_valid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_byte_reg, m_byte_next;
    logic                m_last_reg, m_last_next;
    logic [7:0]          cur_byte;
    logic                is_last;
    logic                load_out;
    logic                cmd_take;

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

    assign is_last  = (idx_reg == gsbf_pkg::gsbf_cmd_bytes(cmd_reg.kind) - IDX_W'(1));
    assign load_out = cmd_valid_reg & (~m_valid_reg | m_ready);
    assign cmd_take = ~cmd_valid_reg | (load_out & is_last);
    assign pop      = ~q_empty & cmd_take;

    // Byte of the current command at the current index
    always_comb begin
        cur_byte = 8'h00;
        case (cmd_reg.kind)
            gsbf_pkg::CMD_START: begin
                cur_byte = gsbf_pkg::gsbf_gz_hdr(idx_reg);
            end
            gsbf_pkg::CMD_DATA_HDR: begin
                case (idx_reg)
                    4'd0:    cur_byte = 8'h00;
                    4'd1:    cur_byte = cmd_reg.blk_len[7:0];
                    4'd2:    cur_byte = cmd_reg.blk_len[15:8];
                    4'd3:    cur_byte = ~cmd_reg.blk_len[7:0];
                    4'd4:    cur_byte = ~cmd_reg.blk_len[15:8];
                    default: cur_byte = cmd_reg.data_byte;
                endcase
            end
            gsbf_pkg::CMD_DATA: begin
                cur_byte = cmd_reg.data_byte;
            end
            gsbf_pkg::CMD_FINISH: begin
                // empty final stored block, then CRC and length LE
                case (idx_reg)
                    4'd0:    cur_byte = 8'h01;
                    4'd1:    cur_byte = 8'h00;
                    4'd2:    cur_byte = 8'h00;
                    4'd3:    cur_byte = 8'hff;
                    4'd4:    cur_byte = 8'hff;
                    4'd5:    cur_byte = cmd_reg.crc[7:0];
                    4'd6:    cur_byte = cmd_reg.crc[15:8];
                    4'd7:    cur_byte = cmd_reg.crc[23:16];
                    4'd8:    cur_byte = cmd_reg.crc[31:24];
                    4'd9:    cur_byte = cmd_reg.total[7:0];
                    4'd10:   cur_byte = cmd_reg.total[15:8];
                    4'd11:   cur_byte = cmd_reg.total[23:16];
                    default: cur_byte = cmd_reg.total[31:24];
                endcase
            end
            default: cur_byte = 8'h00;
        endcase
    end

    // Command register and byte index
    always_comb begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        if (cmd_take) begin
            cmd_valid_next = pop;
            cmd_next       = q_cmd;
            idx_next       = '0;
        end else if (load_out) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Output stage
    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_byte_next  = cur_byte;
            m_last_next  = is_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

endmodule

>>> rtl/core/gzip_stored_block_framer.sv
// ----------------------------------------------------------------------------
// gzip_stored_block_framer
// Frames a plain byte stream as a gzip member of deflate stored blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one transaction per item. Mode start emits the
//   10-byte gzip header and clears CRC and length; mode data passes one byte,
//   preceded by a 5-byte stored-block header when a new block opens (length
//   taken from s_segment_remaining, clamped to 1..65535); mode finish emits
//   the empty final block and the CRC-32 and length trailer (13 bytes).
//   Mode 3 is accepted and dropped.
//   Output channel (m_*): one byte per transaction, m_last marks the final
//   byte caused by an input transaction.
//   Path: an accepted item passes the command queue and the command and output registers.
//   Throughput: while m_ready is high the back end emits one byte per cycle,
//   so plain data bytes pass at one per cycle.
//   The command queue (QUEUE_DEPTH entries) lets the front keep accepting
//   while the back end works through a multi-byte command.
//   Stalls: when m_ready is low the output register holds; once the queue is
//   full s_ready drops.
//   Reset: synchronous active-low aresetn empties the queue and output stage
//   and clears CRC, length and the bytes left in the open block.
// ----------------------------------------------------------------------------
module gzip_stored_block_framer #(
    parameter int unsigned QUEUE_DEPTH = gsbf_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_segment_remaining,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    logic                     push;
    logic                     pop;
    gsbf_pkg::gsbf_cmd_t      push_cmd;
    gsbf_pkg::gsbf_cmd_t      pop_cmd;
    gsbf_pkg::gsbf_q_status_t q_status;

    // Front end: accept and classify
    gsbf_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_data_byte         (s_data_byte),
        .s_segment_remaining (s_segment_remaining),
        .q_status            (q_status),
        .push                (push),
        .push_cmd            (push_cmd)
    );

    // Command queue
    gsbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // Back end: byte emission
    gsbf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_status.empty),
        .q_cmd      (pop_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    // Checks
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_ready_tracks_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.full && !pop) |=> !s_ready)
        else $error("input ready while queue still full");

endmodule
